/* rtl/psarl_pkg.sv */
// shared types and constants for the per-source attempt rate limiter
// used by psarl_table, psarl_scan and per_source_attempt_rate_limiter
`default_nettype none

package psarl_pkg;

  localparam int DEF_TABLE_ENTRIES = 16;

  localparam int ADDR_W  = 32;
  localparam int TIME_W  = 32;
  localparam int CNT_W   = 8;
  localparam int WIN_W   = 16;
  localparam int FREED_W = 5;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 2;

  // reset values of the configuration registers
  localparam logic [CNT_W-1:0] RST_MAX_ATTEMPTS = 8'd5;
  localparam logic [WIN_W-1:0] RST_WINDOW       = 16'd60;
  localparam logic [WIN_W-1:0] RST_IDLE_TIMEOUT = 16'd300;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ATTEMPTS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT = 2'd2;

  // op codes
  localparam logic [1:0] OP_CHECK   = 2'd0;
  localparam logic [1:0] OP_RESET   = 2'd1;
  localparam logic [1:0] OP_CLEANUP = 2'd2;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [TIME_W-1:0] last_time;
    logic [CNT_W-1:0]  count;
  } entry_t;

  typedef struct packed {
    logic match;
    logic free_slot;
    logic oldest;
  } scan_flags_t;

endpackage

`default_nettype wire

/* rtl/psarl_table.sv */
// source table: entry memory with one write and one registered read port,
// plus per-entry valid flops cleared at reset; uses psarl_pkg
`default_nettype none

module psarl_table #(
  parameter int TABLE_ENTRIES = psarl_pkg::DEF_TABLE_ENTRIES,
  parameter int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               rd_en,
  input  wire logic [IDX_W-1:0]   rd_idx,
  output psarl_pkg::entry_t       rd_word_r,
  output logic                    rd_valid_r,
  input  wire logic               wr_en,
  input  wire logic [IDX_W-1:0]   wr_idx,
  input  wire psarl_pkg::entry_t  wr_word,
  input  wire logic               clr_en,
  input  wire logic [IDX_W-1:0]   clr_idx
);

  psarl_pkg::entry_t mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_word;
    end
    if (rd_en) begin
      rd_word_r <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_idx] <= 1'b1;
      end
      if (clr_en) begin
        valid_r[clr_idx] <= 1'b0;
      end
      if (rd_en) begin
        rd_valid_r <= valid_r[rd_idx];
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/psarl_scan.sv */
// scan unit: one entry a cycle through a shared subtract/compare, collecting
// match, first free slot, oldest entry and cleanup frees; uses psarl_pkg
`default_nettype none

module psarl_scan #(
  parameter int TABLE_ENTRIES = psarl_pkg::DEF_TABLE_ENTRIES,
  parameter int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  input  wire logic                             ev,
  input  wire logic [IDX_W-1:0]                 ev_idx,
  input  wire psarl_pkg::entry_t                ent,
  input  wire logic                             ent_vld,
  input  wire logic                             cleanup,
  input  wire logic [psarl_pkg::ADDR_W-1:0]     addr,
  input  wire logic [psarl_pkg::TIME_W-1:0]     now,
  input  wire logic [psarl_pkg::WIN_W-1:0]      idle_timeout,
  output psarl_pkg::scan_flags_t                flags_r,
  output logic [IDX_W-1:0]                      match_idx_r,
  output psarl_pkg::entry_t                     match_word_r,
  output logic [IDX_W-1:0]                      free_idx_r,
  output logic [IDX_W-1:0]                      old_idx_r,
  output logic [psarl_pkg::FREED_W-1:0]         freed_r,
  output logic                                  clr_en,
  output logic [IDX_W-1:0]                      clr_idx
);

  logic [psarl_pkg::TIME_W-1:0] old_time_r;
  logic [psarl_pkg::TIME_W-1:0] op_a;
  logic [psarl_pkg::TIME_W:0]   diff;
  logic                         a_gt;
  logic                         idle_hit;
  logic                         hit;

  // shared subtractor: now - last for cleanup, oldest - last for eviction
  always_comb begin
    op_a     = cleanup ? now : old_time_r;
    diff     = {1'b0, op_a} - {1'b0, ent.last_time};
    a_gt     = !diff[psarl_pkg::TIME_W] && (diff[psarl_pkg::TIME_W-1:0] != '0);
    idle_hit = !diff[psarl_pkg::TIME_W] &&
               (diff[psarl_pkg::TIME_W-1:0] >
                {{(psarl_pkg::TIME_W-psarl_pkg::WIN_W){1'b0}}, idle_timeout});
    hit      = ev && ent_vld && (ent.addr == addr);
    clr_en   = ev && cleanup && ent_vld && idle_hit;
    clr_idx  = ev_idx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
      freed_r <= '0;
    end else if (start) begin
      flags_r <= '0;
      freed_r <= '0;
    end else if (ev) begin
      if (hit && !flags_r.match) begin
        flags_r.match <= 1'b1;
      end
      if (!ent_vld && !flags_r.free_slot) begin
        flags_r.free_slot <= 1'b1;
      end
      if (ent_vld && !cleanup && a_gt) begin
        flags_r.oldest <= 1'b1;
      end
      if (clr_en) begin
        freed_r <= freed_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      old_time_r <= now;
    end else if (ev) begin
      if (hit && !flags_r.match) begin
        match_idx_r  <= ev_idx;
        match_word_r <= ent;
      end
      if (!ent_vld && !flags_r.free_slot) begin
        free_idx_r <= ev_idx;
      end
      // strict compare keeps the first entry on ties
      if (ent_vld && !cleanup && a_gt) begin
        old_idx_r  <= ev_idx;
        old_time_r <= ent.last_time;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/per_source_attempt_rate_limiter.sv */
// per-source attempt rate limiter: after accept, the scan reads one table entry a cycle
// through the whole table, then the drain, select, age and done states follow and the
// result is registered; the next word is accepted only after that, back in idle, so
// words are taken one at a time, and done waits while out_tready holds the result back
// sync reset clears config to defaults and all valid bits at once, no clearing pass
// uses psarl_pkg, psarl_table and psarl_scan
`default_nettype none

module per_source_attempt_rate_limiter #(
  parameter int TABLE_ENTRIES = psarl_pkg::DEF_TABLE_ENTRIES
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [63:0]                       in_tdata,  // source_address, now_seconds
  input  wire logic [1:0]                        in_tuser,  // op
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [7:0]                             out_tdata, // allowed, tracked, evicted,
                                                            // freed_count
  input  wire logic                              cfg_we,
  input  wire logic [psarl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [psarl_pkg::CFG_W-1:0]       cfg_wdata
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_SEL   = 3'd3;
  localparam logic [2:0] S_AGE   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state_r, state_nxt;

  logic [psarl_pkg::CNT_W-1:0] max_attempts_r;
  logic [psarl_pkg::WIN_W-1:0] window_r;
  logic [psarl_pkg::WIN_W-1:0] idle_timeout_r;

  logic [1:0]                   op_r;
  logic [psarl_pkg::ADDR_W-1:0] addr_r;
  logic [psarl_pkg::TIME_W-1:0] now_r;

  logic [IDX_W-1:0] rd_idx_r;
  logic             ev_r;
  logic [IDX_W-1:0] ev_idx_r;

  logic [IDX_W-1:0]            slot_r;
  logic [psarl_pkg::TIME_W-1:0] last_r;
  logic [psarl_pkg::CNT_W-1:0]  cnt_r;
  logic                        have_r;
  logic                        evict_r;
  logic                        expired_r;

  logic                         out_tvalid_r;
  logic [7:0]                   out_tdata_r;

  psarl_pkg::entry_t            rd_word_r;
  logic                         rd_valid_r;
  psarl_pkg::scan_flags_t       flags_r;
  logic [IDX_W-1:0]             match_idx_r;
  psarl_pkg::entry_t            match_word_r;
  logic [IDX_W-1:0]             free_idx_r;
  logic [IDX_W-1:0]             old_idx_r;
  logic [psarl_pkg::FREED_W-1:0] freed_r;
  logic                         clr_en;
  logic [IDX_W-1:0]             clr_idx;

  logic                         in_acc;
  logic                         out_free;
  logic                         rd_en;
  logic                         scan_start;
  logic                         tbl_we;
  psarl_pkg::entry_t            tbl_word;
  logic                         is_check;
  logic                         is_rst;
  logic [psarl_pkg::CNT_W-1:0]  cnt_eff;
  logic [psarl_pkg::TIME_W-1:0] last_eff;
  logic                         res_allowed;
  logic                         res_tracked;
  logic                         res_evicted;
  logic [psarl_pkg::FREED_W-1:0] res_freed;
  logic [psarl_pkg::TIME_W:0]   age_diff;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_tvalid_r || out_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign rd_en      = (state_r == S_SCAN);
  assign scan_start = (state_r == S_SCAN) && (rd_idx_r == '0);

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_attempts_r <= psarl_pkg::RST_MAX_ATTEMPTS;
      window_r       <= psarl_pkg::RST_WINDOW;
      idle_timeout_r <= psarl_pkg::RST_IDLE_TIMEOUT;
    end else if (cfg_we) begin
      case (cfg_index)
        psarl_pkg::REG_MAX_ATTEMPTS: max_attempts_r <= cfg_wdata[psarl_pkg::CNT_W-1:0];
        psarl_pkg::REG_WINDOW:       window_r       <= cfg_wdata;
        psarl_pkg::REG_IDLE_TIMEOUT: idle_timeout_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_acc) state_nxt = S_SCAN;
      S_SCAN:  if (rd_idx_r == LAST_IDX) state_nxt = S_DRAIN;
      S_DRAIN: state_nxt = S_SEL;
      S_SEL:   state_nxt = S_AGE;
      S_AGE:   state_nxt = S_DONE;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ev_r     <= 1'b0;
      rd_idx_r <= '0;
    end else begin
      state_r <= state_nxt;
      ev_r    <= rd_en;
      if (in_acc) begin
        rd_idx_r <= '0;
      end else if (rd_en) begin
        rd_idx_r <= rd_idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    ev_idx_r <= rd_idx_r;
    if (in_acc) begin
      op_r   <= in_tuser;
      addr_r <= in_tdata[31:0];
      now_r  <= in_tdata[63:32];
    end
  end

  psarl_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .IDX_W(IDX_W)
  ) u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (rd_en),
    .rd_idx    (rd_idx_r),
    .rd_word_r (rd_word_r),
    .rd_valid_r(rd_valid_r),
    .wr_en     (tbl_we),
    .wr_idx    (slot_r),
    .wr_word   (tbl_word),
    .clr_en    (clr_en),
    .clr_idx   (clr_idx)
  );

  psarl_scan #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .IDX_W(IDX_W)
  ) u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (scan_start),
    .ev          (ev_r),
    .ev_idx      (ev_idx_r),
    .ent         (rd_word_r),
    .ent_vld     (rd_valid_r),
    .cleanup     (op_r == psarl_pkg::OP_CLEANUP),
    .addr        (addr_r),
    .now         (now_r),
    .idle_timeout(idle_timeout_r),
    .flags_r     (flags_r),
    .match_idx_r (match_idx_r),
    .match_word_r(match_word_r),
    .free_idx_r  (free_idx_r),
    .old_idx_r   (old_idx_r),
    .freed_r     (freed_r),
    .clr_en      (clr_en),
    .clr_idx     (clr_idx)
  );

  // slot choice: existing entry, else first free, else oldest before now
  always_ff @(posedge clk) begin
    if (state_r == S_SEL) begin
      if (flags_r.match) begin
        slot_r  <= match_idx_r;
        last_r  <= match_word_r.last_time;
        cnt_r   <= match_word_r.count;
        have_r  <= 1'b1;
        evict_r <= 1'b0;
      end else if (flags_r.free_slot) begin
        slot_r  <= free_idx_r;
        last_r  <= now_r;
        cnt_r   <= '0;
        have_r  <= 1'b1;
        evict_r <= 1'b0;
      end else if (flags_r.oldest) begin
        slot_r  <= old_idx_r;
        last_r  <= now_r;
        cnt_r   <= '0;
        have_r  <= 1'b1;
        evict_r <= 1'b1;
      end else begin
        have_r  <= 1'b0;
        evict_r <= 1'b0;
      end
    end
  end

  // window test; time going backwards never expires
  assign age_diff = {1'b0, now_r} - {1'b0, last_r};

  always_ff @(posedge clk) begin
    if (state_r == S_AGE) begin
      expired_r <= !age_diff[psarl_pkg::TIME_W] &&
                   (age_diff[psarl_pkg::TIME_W-1:0] >
                    {{(psarl_pkg::TIME_W-psarl_pkg::WIN_W){1'b0}}, window_r});
    end
  end

  // result and write-back
  always_comb begin
    is_check    = (op_r == psarl_pkg::OP_CHECK) && (addr_r != '0);
    is_rst      = (op_r == psarl_pkg::OP_RESET) && (addr_r != '0);
    cnt_eff     = expired_r ? '0 : cnt_r;
    last_eff    = expired_r ? now_r : last_r;
    res_allowed = 1'b1;
    res_tracked = 1'b0;
    res_evicted = 1'b0;
    res_freed   = '0;
    tbl_we      = 1'b0;
    tbl_word    = '{addr: addr_r, last_time: now_r, count: '0};
    if (is_check && have_r) begin
      res_tracked = 1'b1;
      res_evicted = evict_r;
      tbl_we      = 1'b1;
      if (cnt_eff >= max_attempts_r) begin
        res_allowed = 1'b0;
        tbl_word    = '{addr: addr_r, last_time: last_eff, count: cnt_eff};
      end else begin
        tbl_word = '{addr: addr_r, last_time: now_r, count: cnt_eff + 1'b1};
      end
    end else if (is_rst && flags_r.match) begin
      res_tracked = 1'b1;
      tbl_we      = 1'b1;
    end else if (op_r == psarl_pkg::OP_CLEANUP) begin
      res_freed = freed_r;
    end
    tbl_we = tbl_we && (state_r == S_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if ((state_r == S_DONE) && out_free) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_DONE) && out_free) begin
      out_tdata_r <= {res_freed, res_evicted, res_tracked, res_allowed};
    end
  end

  // checks
  a_we_only_done: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_we |-> (state_r == S_DONE))
    else $error("table written outside completion");

  a_clr_only_cleanup: assert property (@(posedge clk) disable iff (!rst_n)
    clr_en |-> (op_r == psarl_pkg::OP_CLEANUP) && (state_r == S_SCAN || state_r == S_DRAIN))
    else $error("entry freed outside a cleanup sweep");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r == S_DONE))
    else $error("result raised without finishing a word");

  a_evict_tracked: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && out_tdata_r[2] |-> out_tdata_r[1] && (out_tdata_r[7:3] == '0))
    else $error("eviction reported without tracking");

endmodule

`default_nettype wire
